>>> hw/rtl/hed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_pkg
// Shared types, character codes and the named-entity table of the decoder.
// ----------------------------------------------------------------------------
package hed_pkg;

  localparam int ENTITY_WINDOW_DEF = 10;
  localparam int NUM_NAMES = 35;
  localparam int NAME_BYTES = 6;

  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [31:0] NBSP_CODE = 32'h0000_00A0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       out_end;
  } out_item_t;

  typedef enum logic [1:0] {
    EMIT_CUR,
    EMIT_AMP,
    EMIT_ENC
  } emit_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    emit_sel_t emit_sel;
    logic      direct;
    logic      flush;
    logic      drop;
    logic      cnt_inc;
    logic      cnt_dec;
    logic      cnt_clr;
    logic      num_setup;
    logic      num_step;
    logic      code_rom;
    logic      enc_clr;
    logic      enc_inc;
    logic      sel_idx;
  } hed_cmd_t;

  typedef struct packed {
    logic       have;
    logic       cnt_zero;
    logic       cnt_one;
    logic       len_one;
    logic       cur_amp;
    logic       at_end;
    logic       term_now;
    logic       d_ok;
    logic       is_num;
    logic       semi;
    logic       name_hit;
    logic       num_more;
    logic       code_zero;
    logic [1:0] nb;
    logic [1:0] enc_idx;
    logic       can_emit;
    logic       can_flush;
    logic       h_valid;
  } hed_stat_t;

  typedef struct packed {
    logic        hit;
    logic [15:0] cp;
  } name_hit_t;

  localparam logic [47:0] ROM_NAME [NUM_NAMES] = '{
    48'("quot"), 48'("amp"), 48'("lt"), 48'("gt"), 48'("nbsp"), 48'("apos"),
    48'("copy"), 48'("reg"), 48'("trade"), 48'("euro"), 48'("pound"),
    48'("yen"), 48'("ndash"), 48'("mdash"), 48'("lsquo"), 48'("rsquo"),
    48'("ldquo"), 48'("rdquo"), 48'("hellip"), 48'("bull"), 48'("middot"),
    48'("times"), 48'("divide"), 48'("plusmn"), 48'("micro"), 48'("para"),
    48'("sect"), 48'("deg"), 48'("frac14"), 48'("frac12"), 48'("frac34"),
    48'("iquest"), 48'("iexcl"), 48'("laquo"), 48'("raquo")
  };

  localparam logic [2:0] ROM_LEN [NUM_NAMES] = '{
    3'd4, 3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd4, 3'd5,
    3'd3, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd4, 3'd6,
    3'd5, 3'd6, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd6, 3'd6, 3'd6,
    3'd6, 3'd5, 3'd5, 3'd5
  };

  localparam logic [15:0] ROM_CP [NUM_NAMES] = '{
    16'h0022, 16'h0026, 16'h003C, 16'h003E, 16'h0020, 16'h0027, 16'h00A9,
    16'h00AE, 16'h2122, 16'h20AC, 16'h00A3, 16'h00A5, 16'h2013, 16'h2014,
    16'h0027, 16'h0027, 16'h0022, 16'h0022, 16'h2026, 16'h2022, 16'h00B7,
    16'h00D7, 16'h00F7, 16'h00B1, 16'h00B5, 16'h00B6, 16'h00A7, 16'h00B0,
    16'h00BC, 16'h00BD, 16'h00BE, 16'h00BF, 16'h00A1, 16'h00AB, 16'h00BB
  };

  // key holds the name with its first character in the top byte
  function automatic name_hit_t name_lookup(input logic [47:0] key,
                                            input logic [7:0] nlen);
    name_hit_t r;
    r.hit = 1'b0;
    r.cp  = '0;
    for (int k = 0; k < NUM_NAMES; k++) begin
      if (nlen == 8'(ROM_LEN[k]) &&
          (key >> (8 * (NAME_BYTES - int'(ROM_LEN[k])))) == ROM_NAME[k]) begin
        r.hit = 1'b1;
        r.cp  = ROM_CP[k];
      end
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/hed_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface hed_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/html_entity_decoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// html_entity_decoder_top
// Streaming HTML character-entity decoder producing UTF-8 bytes.
//
//   channel | direction | payload                       | per handshake
//   rx      | in        | in_byte, in_last              | one text byte
//   tx      | out       | out_byte, out_last, out_end   | one decoded byte
//
// A plain byte is loaded and then held or passed on; an opening '&' starts
// an entity in the buffer. A closing byte leads to a resolve step, then for
// a numeric code to accumulating its digits, then to emitting its UTF-8
// bytes (none when the code is out of range), dropping the buffered bytes and
// releasing the last result; a failed entity emits the raw '&' and rescans
// its buffered bytes. The scan sequencer sets the rate; rx is taken only in idle.
// Reset (synchronous) empties the buffer and the result registers.
// A stall on tx holds the sequencer wherever it next needs to emit.
// ----------------------------------------------------------------------------
module html_entity_decoder_top import hed_pkg::*; #(
  parameter int ENTITY_WINDOW = ENTITY_WINDOW_DEF
) (
  input logic         clk,
  input logic         rst,
  hed_stream_if.sink   rx,
  hed_stream_if.source tx
);

  hed_cmd_t  cmd;
  hed_stat_t stat;

  hed_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (rx.valid),
    .in_ready (rx.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hed_datapath #(
    .ENTITY_WINDOW (ENTITY_WINDOW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (rx.payload),
    .out_valid (tx.valid),
    .out_ready (tx.ready),
    .out_item  (tx.payload)
  );

endmodule

>>> hw/rtl/hed_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_datapath
// Lookahead buffer with rescan queue, numeric accumulator, name lookup,
// UTF-8 encoder and the held/output result registers.
// ----------------------------------------------------------------------------
module hed_datapath import hed_pkg::*; #(
  parameter int ENTITY_WINDOW = ENTITY_WINDOW_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  hed_cmd_t  cmd,
  output hed_stat_t stat,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  localparam int DEPTH = ENTITY_WINDOW + 1;
  localparam int CW = $clog2(ENTITY_WINDOW + 2);
  localparam int AW = $clog2(DEPTH);

  // buffer bytes sit below cnt, bytes waiting for rescan between cnt and len
  logic [7:0]    la_buf [DEPTH];
  logic [CW-1:0] len;
  logic [CW-1:0] cnt;
  logic [CW-1:0] idx;
  logic [CW-1:0] limit;
  logic          last_q;
  logic          term_q;
  logic          semi_q;
  logic          hex_q;
  logic [31:0]   code;
  logic [1:0]    enc_idx;

  logic          h_valid;
  logic [7:0]    h_byte;
  logic          o_valid;
  logic [7:0]    o_byte;
  logic          o_last;
  logic          o_end;

  logic [CW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [CW-1:0] d_len;
  logic          hex_now;
  logic [47:0]   key;
  name_hit_t     nh;
  logic [3:0]    dig;
  logic          dig_ok;
  logic [31:0]   code_next;
  logic [31:0]   ec;
  logic [1:0]    nb;
  logic [7:0]    enc_byte;
  logic [7:0]    emit_val;

  assign rd_addr = cmd.sel_idx ? idx : cnt;
  assign rd_data = (rd_addr < CW'(DEPTH)) ? la_buf[rd_addr[AW-1:0]] : 8'h00;
  assign d_len   = term_q ? cnt - CW'(1) : cnt;
  assign hex_now = (la_buf[2] == CH_X_LO) || (la_buf[2] == CH_X_UP);

  always_comb begin
    key = '0;
    for (int j = 0; j < NAME_BYTES; j++) begin
      if (j + 1 <= ENTITY_WINDOW) begin
        key[8*(NAME_BYTES-1-j) +: 8] =
          la_buf[(j + 1 <= ENTITY_WINDOW) ? j + 1 : ENTITY_WINDOW];
      end
    end
  end

  assign nh = name_lookup(key, 8'(cnt) - 8'd2);

  always_comb begin
    dig    = 4'd0;
    dig_ok = 1'b0;
    if (rd_data >= 8'h30 && rd_data <= 8'h39) begin
      dig    = rd_data[3:0];
      dig_ok = 1'b1;
    end else if (hex_q && ((rd_data >= 8'h61 && rd_data <= 8'h66) ||
                           (rd_data >= 8'h41 && rd_data <= 8'h46))) begin
      dig    = rd_data[3:0] + 4'd9;
      dig_ok = 1'b1;
    end
  end

  assign code_next = hex_q ? {code[27:0], dig}
                           : (code << 3) + (code << 1) + 32'(dig);

  assign ec = (code == NBSP_CODE) ? 32'(CH_SPACE) : code;

  always_comb begin
    if (ec < 32'h80)         nb = 2'd1;
    else if (ec < 32'h800)   nb = 2'd2;
    else if (ec < 32'h10000) nb = 2'd3;
    else                     nb = 2'd0;
  end

  always_comb begin
    enc_byte = ec[7:0];
    if (nb == 2'd2) begin
      enc_byte = (enc_idx == 2'd0) ? {3'b110, ec[10:6]} : {2'b10, ec[5:0]};
    end else if (nb == 2'd3) begin
      case (enc_idx)
        2'd0:    enc_byte = {4'b1110, ec[15:12]};
        2'd1:    enc_byte = {2'b10, ec[11:6]};
        default: enc_byte = {2'b10, ec[5:0]};
      endcase
    end
  end

  always_comb begin
    unique case (cmd.emit_sel)
      EMIT_CUR: emit_val = rd_data;
      EMIT_AMP: emit_val = CH_AMP;
      EMIT_ENC: emit_val = enc_byte;
      default:  emit_val = rd_data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len     <= '0;
      cnt     <= '0;
      h_valid <= 1'b0;
      o_valid <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      if ((cmd.emit && h_valid) || cmd.flush || cmd.direct) o_valid <= 1'b1;
      else if (out_ready) o_valid <= 1'b0;
      if (cmd.emit) begin
        if (h_valid) begin
          o_byte  <= h_byte;
          o_last  <= 1'b0;
          o_end   <= 1'b0;
        end
        h_byte  <= emit_val;
        h_valid <= 1'b1;
      end
      if (cmd.flush) begin
        o_byte  <= h_byte;
        o_last  <= 1'b1;
        o_end   <= last_q;
        h_valid <= 1'b0;
      end
      if (cmd.direct) begin
        o_byte  <= rd_data;
        o_last  <= 1'b1;
        o_end   <= last_q;
      end
      if (cmd.load) begin
        la_buf[len[AW-1:0]] <= in_item.in_byte;
        len    <= len + CW'(1);
        last_q <= in_item.in_last;
      end
      if (cmd.drop) begin
        for (int j = 0; j < DEPTH - 1; j++) la_buf[j] <= la_buf[j+1];
        len <= len - CW'(1);
      end
      if (cmd.cnt_inc) begin
        cnt    <= cnt + CW'(1);
        term_q <= stat.term_now;
        semi_q <= (rd_data == CH_SEMI);
      end
      if (cmd.cnt_dec) cnt <= cnt - CW'(1);
      if (cmd.cnt_clr) cnt <= '0;
      if (cmd.num_setup) begin
        hex_q <= hex_now;
        idx   <= hex_now ? CW'(3) : CW'(2);
        limit <= hex_now ? cnt : cnt - CW'(1);
        code  <= '0;
      end
      if (cmd.num_step) begin
        code <= code_next;
        idx  <= idx + CW'(1);
      end
      if (cmd.code_rom) code <= {16'h0000, nh.cp};
      if (cmd.enc_clr)  enc_idx <= 2'd0;
      if (cmd.enc_inc)  enc_idx <= enc_idx + 2'd1;
    end
  end

  always_comb begin
    stat.have      = cnt < len;
    stat.cnt_zero  = cnt == '0;
    stat.cnt_one   = cnt == CW'(1);
    stat.len_one   = len == CW'(1);
    stat.cur_amp   = rd_data == CH_AMP;
    stat.at_end    = last_q && ((cnt + CW'(1)) == len);
    stat.term_now  = (rd_data == CH_SEMI) || (cnt >= CW'(ENTITY_WINDOW));
    stat.d_ok      = d_len > CW'(2);
    stat.is_num    = la_buf[1] == CH_HASH;
    stat.semi      = semi_q;
    stat.name_hit  = nh.hit;
    stat.num_more  = (idx < limit) && dig_ok;
    stat.code_zero = code == '0;
    stat.nb        = nb;
    stat.enc_idx   = enc_idx;
    stat.can_emit  = !h_valid || !o_valid || out_ready;
    stat.can_flush = !o_valid || out_ready;
    stat.h_valid   = h_valid;
  end

  assign out_valid         = o_valid;
  assign out_item.out_byte = o_byte;
  assign out_item.out_last = o_last;
  assign out_item.out_end  = o_end;

  a_cnt_in_len: assert property (@(posedge clk) disable iff (rst) cnt <= len)
    else $error("buffer count beyond held bytes");
  a_len_depth: assert property (@(posedge clk) disable iff (rst) len <= CW'(DEPTH))
    else $error("held bytes beyond buffer depth");
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_end |-> o_last)
    else $error("end of text on an item that is not last");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    o_valid && !out_ready |=> o_valid && $stable(o_byte))
    else $error("output item changed while stalled");

endmodule

>>> hw/rtl/hed_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hed_ctrl
// Sequencer: scan bytes, resolve entities, accumulate digits, emit UTF-8.
// ----------------------------------------------------------------------------
module hed_ctrl import hed_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  hed_stat_t stat,
  output hed_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RES,
    ST_NUM,
    ST_ENC,
    ST_FAIL,
    ST_DROP
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.emit_sel = EMIT_CUR;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stat.have) begin
          // end of item: release the held byte as the last result
          if (!stat.h_valid) begin
            state_next = ST_IDLE;
          end else if (stat.can_flush) begin
            cmd.flush  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (stat.cnt_zero) begin
          if (stat.cur_amp && !stat.at_end) begin
            cmd.cnt_inc = 1'b1;
          end else if (!stat.h_valid && stat.len_one && stat.can_flush) begin
            cmd.direct = 1'b1;
            cmd.drop   = 1'b1;
            state_next = ST_IDLE;
          end else if (stat.can_emit) begin
            cmd.emit = 1'b1;
            cmd.drop = 1'b1;
          end
        end else begin
          cmd.cnt_inc = 1'b1;
          if (stat.term_now || stat.at_end) state_next = ST_RES;
        end
      end
      ST_RES: begin
        if (!stat.d_ok) begin
          state_next = ST_FAIL;
        end else if (stat.is_num) begin
          cmd.num_setup = 1'b1;
          state_next    = ST_NUM;
        end else if (stat.semi && stat.name_hit) begin
          cmd.code_rom = 1'b1;
          cmd.enc_clr  = 1'b1;
          state_next   = ST_ENC;
        end else begin
          state_next = ST_FAIL;
        end
      end
      ST_NUM: begin
        cmd.sel_idx = 1'b1;
        if (stat.num_more) begin
          cmd.num_step = 1'b1;
        end else if (stat.code_zero) begin
          state_next = ST_FAIL;
        end else begin
          cmd.enc_clr = 1'b1;
          state_next  = ST_ENC;
        end
      end
      ST_ENC: begin
        cmd.emit_sel = EMIT_ENC;
        if (stat.nb == 2'd0) begin
          state_next = ST_DROP;
        end else if (stat.can_emit) begin
          cmd.emit = 1'b1;
          if (stat.enc_idx == stat.nb - 2'd1) state_next = ST_DROP;
          else cmd.enc_inc = 1'b1;
        end
      end
      ST_FAIL: begin
        // pass '&' raw and rescan what followed it
        cmd.emit_sel = EMIT_AMP;
        if (stat.can_emit) begin
          cmd.emit    = 1'b1;
          cmd.drop    = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_DROP: begin
        cmd.drop    = 1'b1;
        cmd.cnt_dec = 1'b1;
        if (stat.cnt_one) state_next = ST_SCAN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !stat.h_valid)
    else $error("held result left behind at end of item");
  a_load_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == ST_SCAN)
    else $error("accepted item not scanned");
  a_drop_buf: assert property (@(posedge clk) disable iff (rst)
    state == ST_DROP |-> !stat.cnt_zero)
    else $error("drop with empty buffer");

endmodule
